// ----- hw/rtl/l3cg_pkg.sv -----
package l3cg_pkg;

    // Field widths
    localparam int ADDR_W     = 15;
    localparam int CH_W       = 16;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 5;
    localparam int FRAC_W     = 4;
    localparam int WEIGHT_W   = 5;
    localparam int PROD_W     = CH_W + WEIGHT_W;
    localparam int SCALED_W   = 32;
    localparam int ENTRY_W    = 3 * CH_W;

    // Cube geometry: large cube has edge 32 (cell width 8), small edge 16 (cell 16)
    localparam int CUBE_EDGE  = 32;
    localparam int SMALL_EDGE = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam logic [IDX_W-1:0] IDX_MAX_LARGE = IDX_W'(CUBE_EDGE - 2);
    localparam logic [IDX_W-1:0] IDX_MAX_SMALL = IDX_W'(SMALL_EDGE - 2);
    localparam logic [WEIGHT_W-1:0] CELL_LARGE = WEIGHT_W'(256 / CUBE_EDGE);
    localparam logic [WEIGHT_W-1:0] CELL_SMALL = WEIGHT_W'(256 / SMALL_EDGE);

    // ceil(2^24 / 257): x / 257 == (x * RECIP_257) >> 24 for any 16-bit x
    localparam logic [15:0] RECIP_257 = 16'hFF01;
    localparam int RECIP_SHIFT = 24;

    // Queue sizes
    localparam int OPQ_DEPTH    = 4;
    localparam int OPQ_PTR_W    = 2;
    localparam int OPQ_CNT_W    = 3;
    localparam int OUTQ_DEPTH   = 8;
    localparam int OUTQ_PTR_W   = 3;
    localparam int OUTQ_CNT_W   = 4;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_GRADE = 1'b1
    } cmd_t;

    typedef enum logic
    {
        EDGE_32 = 1'b0,
        EDGE_16 = 1'b1
    } edge_mode_t;

    // One classified request as it travels from front to back
    typedef struct packed
    {
        cmd_t                 cmd;
        edge_mode_t           mode;
        logic [ADDR_W-1:0]    addr_a;     // write address, or base corner
        logic [ADDR_W-1:0]    addr_b;     // diagonal corner
        logic [ENTRY_W-1:0]   entry;      // {red, green, blue}
        logic [3*FRAC_W-1:0]  frac;       // {red, green, blue}
    } op_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } result_t;

    typedef struct packed
    {
        logic                 full;
        logic                 empty;
        logic [OPQ_CNT_W-1:0] count;
    } opq_stat_t;

    typedef struct packed
    {
        logic [OUTQ_CNT_W-1:0] credits;
        logic [OUTQ_CNT_W-1:0] out_count;
    } back_stat_t;

endpackage

// ----- hw/rtl/l3cg_in_if.sv -----
interface l3cg_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [l3cg_pkg::ADDR_W-1:0]    entry_index;
    logic [l3cg_pkg::CH_W-1:0]      entry_red;
    logic [l3cg_pkg::CH_W-1:0]      entry_green;
    logic [l3cg_pkg::CH_W-1:0]      entry_blue;
    logic [l3cg_pkg::PIX_W-1:0]     pixel_red;
    logic [l3cg_pkg::PIX_W-1:0]     pixel_green;
    logic [l3cg_pkg::PIX_W-1:0]     pixel_blue;

    modport source
    (
        output valid, command, entry_index, entry_red, entry_green, entry_blue,
        output pixel_red, pixel_green, pixel_blue,
        input  ready
    );

    modport sink
    (
        input  valid, command, entry_index, entry_red, entry_green, entry_blue,
        input  pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

// ----- hw/rtl/l3cg_out_if.sv -----
interface l3cg_out_if;
    logic                           valid;
    logic                           ready;
    logic [l3cg_pkg::PIX_W-1:0]     graded_red;
    logic [l3cg_pkg::PIX_W-1:0]     graded_green;
    logic [l3cg_pkg::PIX_W-1:0]     graded_blue;

    modport source
    (
        output valid, graded_red, graded_green, graded_blue,
        input  ready
    );

    modport sink
    (
        input  valid, graded_red, graded_green, graded_blue,
        output ready
    );
endinterface

// ----- hw/rtl/l3cg_front.sv -----
module l3cg_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    l3cg_in_if.sink             pix_in,
    output l3cg_pkg::op_t       op,
    output logic                op_valid,
    input  logic                op_ready
);

    l3cg_pkg::edge_mode_t edge_mode_reg;
    l3cg_pkg::edge_mode_t edge_mode_next;

    logic [l3cg_pkg::IDX_W-1:0]  idx_r, idx_g, idx_b;
    logic [l3cg_pkg::IDX_W-1:0]  nxt_r, nxt_g, nxt_b;
    logic [l3cg_pkg::ADDR_W-1:0] base_addr, diag_addr;

    // Cube index of one channel, clamped so that the diagonal corner exists
    function automatic logic [l3cg_pkg::IDX_W-1:0] cube_idx
    (
        input logic [l3cg_pkg::PIX_W-1:0] v,
        input l3cg_pkg::edge_mode_t       m
    );
        logic [l3cg_pkg::IDX_W-1:0] i;
        if (m == l3cg_pkg::EDGE_16)
        begin
            i = {1'b0, v[7:4]};
            if (i > l3cg_pkg::IDX_MAX_SMALL)
                i = l3cg_pkg::IDX_MAX_SMALL;
        end
        else
        begin
            i = v[7:3];
            if (i > l3cg_pkg::IDX_MAX_LARGE)
                i = l3cg_pkg::IDX_MAX_LARGE;
        end
        return i;
    endfunction

    // Fraction keeps the low bits of the value, even where the index is clamped
    function automatic logic [l3cg_pkg::FRAC_W-1:0] cube_frac
    (
        input logic [l3cg_pkg::PIX_W-1:0] v,
        input l3cg_pkg::edge_mode_t       m
    );
        logic [l3cg_pkg::FRAC_W-1:0] f;
        if (m == l3cg_pkg::EDGE_16)
            f = v[3:0];
        else
            f = {1'b0, v[2:0]};
        return f;
    endfunction

    // Mode register
    always_comb
    begin
        edge_mode_next = edge_mode_reg;
        if (cfg_write)
            edge_mode_next = l3cg_pkg::edge_mode_t'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_mode_reg <= l3cg_pkg::EDGE_32;
        else
            edge_mode_reg <= edge_mode_next;
    end

    // Corner indices
    always_comb
    begin
        idx_r = cube_idx(pix_in.pixel_red,   edge_mode_reg);
        idx_g = cube_idx(pix_in.pixel_green, edge_mode_reg);
        idx_b = cube_idx(pix_in.pixel_blue,  edge_mode_reg);
        nxt_r = idx_r + 5'd1;
        nxt_g = idx_g + 5'd1;
        nxt_b = idx_b + 5'd1;
    end

    // Linear addresses: red fastest, blue slowest
    always_comb
    begin
        if (edge_mode_reg == l3cg_pkg::EDGE_16)
        begin
            base_addr = {3'b000, idx_b[3:0], idx_g[3:0], idx_r[3:0]};
            diag_addr = {3'b000, nxt_b[3:0], nxt_g[3:0], nxt_r[3:0]};
        end
        else
        begin
            base_addr = {idx_b, idx_g, idx_r};
            diag_addr = {nxt_b, nxt_g, nxt_r};
        end
    end

    // Classify the request
    always_comb
    begin
        op.cmd   = l3cg_pkg::cmd_t'(pix_in.command);
        op.mode  = edge_mode_reg;
        op.entry = {pix_in.entry_red, pix_in.entry_green, pix_in.entry_blue};
        op.frac  = {cube_frac(pix_in.pixel_red,   edge_mode_reg),
                    cube_frac(pix_in.pixel_green, edge_mode_reg),
                    cube_frac(pix_in.pixel_blue,  edge_mode_reg)};
        if (op.cmd == l3cg_pkg::CMD_LOAD)
        begin
            op.addr_a = pix_in.entry_index;
            op.addr_b = pix_in.entry_index;
        end
        else
        begin
            op.addr_a = base_addr;
            op.addr_b = diag_addr;
        end
    end

    assign op_valid     = pix_in.valid;
    assign pix_in.ready = op_ready;

endmodule

// ----- hw/rtl/l3cg_queue.sv -----
module l3cg_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  l3cg_pkg::op_t           push_op,
    input  logic                    push_valid,
    output logic                    push_ready,
    output l3cg_pkg::op_t           head_op,
    output logic                    head_valid,
    input  logic                    pop,
    output l3cg_pkg::opq_stat_t     stat
);

    l3cg_pkg::op_t                      slot_reg [l3cg_pkg::OPQ_DEPTH];
    logic [l3cg_pkg::OPQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [l3cg_pkg::OPQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [l3cg_pkg::OPQ_CNT_W-1:0]     count_reg, count_next;
    logic                               full, empty, do_push, do_pop;

    assign full    = (count_reg == l3cg_pkg::OPQ_CNT_W'(l3cg_pkg::OPQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    assign push_ready  = !full;
    assign head_op     = slot_reg[rd_ptr_reg];
    assign head_valid  = !empty;
    assign stat.full   = full;
    assign stat.empty  = empty;
    assign stat.count  = count_reg;

endmodule

// ----- hw/rtl/l3cg_back.sv -----
module l3cg_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  l3cg_pkg::op_t           head_op,
    input  logic                    head_valid,
    output logic                    pop,
    l3cg_out_if.source              res_out,
    output l3cg_pkg::back_stat_t    stat
);

    localparam int CW = l3cg_pkg::CH_W;
    localparam int FW = l3cg_pkg::FRAC_W;

    // Cube store: one write or two reads per cycle
    logic [l3cg_pkg::ENTRY_W-1:0] cube_mem [l3cg_pkg::STORE_DEPTH];

    logic                           issue_grade, issue_load;
    logic [l3cg_pkg::ENTRY_W-1:0]   rd_base_reg, rd_diag_reg;

    // Stage 1: corners read
    logic                           s1_valid_reg;
    l3cg_pkg::edge_mode_t           s1_mode_reg;
    logic [3*FW-1:0]                s1_frac_reg;

    // Stage 2: weighted corners
    logic                           s2_valid_reg;
    l3cg_pkg::edge_mode_t           s2_mode_reg;
    logic [l3cg_pkg::PROD_W-1:0]    prod_s_reg [3];
    logic [l3cg_pkg::PROD_W-1:0]    prod_e_reg [3];
    logic [l3cg_pkg::PROD_W-1:0]    prod_s_next [3];
    logic [l3cg_pkg::PROD_W-1:0]    prod_e_next [3];

    // Stage 3: scaled by 1/257
    logic                           s3_valid_reg;
    logic [l3cg_pkg::SCALED_W-1:0]  scaled_reg [3];
    logic [l3cg_pkg::SCALED_W-1:0]  scaled_next [3];

    // Output queue and credits
    l3cg_pkg::result_t              outq_reg [l3cg_pkg::OUTQ_DEPTH];
    l3cg_pkg::result_t              res_next;
    logic [l3cg_pkg::OUTQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [l3cg_pkg::OUTQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [l3cg_pkg::OUTQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;
    logic [l3cg_pkg::OUTQ_CNT_W-1:0] credits_reg, credits_next;
    logic                            out_take;

    // Issue: a grade needs a free output slot reserved, a load goes any time
    assign issue_load  = head_valid && (head_op.cmd == l3cg_pkg::CMD_LOAD);
    assign issue_grade = head_valid && (head_op.cmd == l3cg_pkg::CMD_GRADE)
                         && (credits_reg < l3cg_pkg::OUTQ_CNT_W'(l3cg_pkg::OUTQ_DEPTH));
    assign pop         = issue_load || issue_grade;

    // Store access; a grade issued after a load sees its data next cycle
    always_ff @(posedge clk)
    begin
        if (issue_load)
            cube_mem[head_op.addr_a] <= head_op.entry;
        if (issue_grade)
        begin
            rd_base_reg <= cube_mem[head_op.addr_a];
            rd_diag_reg <= cube_mem[head_op.addr_b];
        end
    end

    // Weights: start by (cell - f), end by f
    always_comb
    begin
        logic [l3cg_pkg::WEIGHT_W-1:0] cell_w;
        logic [l3cg_pkg::WEIGHT_W-1:0] f;
        logic [CW-1:0]                 s, e;
        cell_w = (s1_mode_reg == l3cg_pkg::EDGE_16) ? l3cg_pkg::CELL_SMALL
                                                    : l3cg_pkg::CELL_LARGE;
        for (int k = 0; k < 3; k++)
        begin
            f = {1'b0, s1_frac_reg[(2-k)*FW +: FW]};
            s = rd_base_reg[(2-k)*CW +: CW];
            e = rd_diag_reg[(2-k)*CW +: CW];
            prod_s_next[k] = l3cg_pkg::PROD_W'(s) * l3cg_pkg::PROD_W'(cell_w - f);
            prod_e_next[k] = l3cg_pkg::PROD_W'(e) * l3cg_pkg::PROD_W'(f);
        end
    end

    // Sum, divide by cell width (a shift), then by 257 via reciprocal
    always_comb
    begin
        logic [l3cg_pkg::PROD_W-1:0] sum;
        logic [CW-1:0]               by_cell;
        for (int k = 0; k < 3; k++)
        begin
            sum = prod_s_reg[k] + prod_e_reg[k];
            if (s2_mode_reg == l3cg_pkg::EDGE_16)
                by_cell = sum[19:4];
            else
                by_cell = sum[18:3];
            scaled_next[k] = l3cg_pkg::SCALED_W'(by_cell)
                             * l3cg_pkg::SCALED_W'(l3cg_pkg::RECIP_257);
        end
    end

    // Quotient is at most 255 since the sum never exceeds 65535 * cell
    assign res_next.red   = scaled_reg[0][l3cg_pkg::RECIP_SHIFT +: l3cg_pkg::PIX_W];
    assign res_next.green = scaled_reg[1][l3cg_pkg::RECIP_SHIFT +: l3cg_pkg::PIX_W];
    assign res_next.blue  = scaled_reg[2][l3cg_pkg::RECIP_SHIFT +: l3cg_pkg::PIX_W];

    // Pipeline data
    always_ff @(posedge clk)
    begin
        s1_mode_reg <= head_op.mode;
        s1_frac_reg <= head_op.frac;
        s2_mode_reg <= s1_mode_reg;
        for (int k = 0; k < 3; k++)
        begin
            prod_s_reg[k] <= prod_s_next[k];
            prod_e_reg[k] <= prod_e_next[k];
            scaled_reg[k] <= scaled_next[k];
        end
        if (s3_valid_reg)
            outq_reg[oq_wr_reg] <= res_next;
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_grade;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Output queue control and credit count
    assign out_take = res_out.valid && res_out.ready;

    always_comb
    begin
        oq_wr_next   = oq_wr_reg;
        oq_rd_next   = oq_rd_reg;
        oq_cnt_next  = oq_cnt_reg;
        credits_next = credits_reg;
        if (s3_valid_reg)
            oq_wr_next = oq_wr_reg + 1'b1;
        if (out_take)
            oq_rd_next = oq_rd_reg + 1'b1;
        if (s3_valid_reg && !out_take)
            oq_cnt_next = oq_cnt_reg + 1'b1;
        else if (out_take && !s3_valid_reg)
            oq_cnt_next = oq_cnt_reg - 1'b1;
        if (issue_grade && !out_take)
            credits_next = credits_reg + 1'b1;
        else if (out_take && !issue_grade)
            credits_next = credits_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
            credits_reg <= '0;
        end
        else
        begin
            oq_wr_reg   <= oq_wr_next;
            oq_rd_reg   <= oq_rd_next;
            oq_cnt_reg  <= oq_cnt_next;
            credits_reg <= credits_next;
        end
    end

    assign res_out.valid        = (oq_cnt_reg != '0);
    assign res_out.graded_red   = outq_reg[oq_rd_reg].red;
    assign res_out.graded_green = outq_reg[oq_rd_reg].green;
    assign res_out.graded_blue  = outq_reg[oq_rd_reg].blue;

    assign stat.credits   = credits_reg;
    assign stat.out_count = oq_cnt_reg;

endmodule

// ----- hw/rtl/lut3d_color_grade.sv -----
// 3D lookup-cube colour grader.
// pix_in carries requests: command 0 loads one cube entry (entry_index, 16-bit
// red/green/blue, 65535 = 1.0), command 1 grades one 8-bit RGB pixel. res_out
// carries one graded pixel for every grade request, in request order; loads
// give no result. Both channels use valid/ready; a request moves on an edge
// with both high. cfg_write/cfg_data set the cube edge (0 = 32, 1 = 16) and
// may only be written while the block is idle.
// A grade request accepted into an empty block passes the queue slot, corner
// read, weighting, 1/257 scaling and output queue registers, then shows on
// res_out. While res_out takes results, throughput is one request per cycle,
// loads and grades mixed, set by the store's one write or two reads per cycle.
// Cube entries must be loaded before a pixel reads them; the store is not
// cleared and needs no clearing pass. Reset empties both queues and sets the
// 32-entry edge.
// When res_out stalls, up to eight results wait in the output queue and four
// requests in the input queue; after that pix_in.ready drops. A load at the
// head of the input queue still drains; requests behind a waiting grade stay.
module lut3d_color_grade
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    l3cg_in_if.sink     pix_in,
    l3cg_out_if.source  res_out
);

    l3cg_pkg::op_t          front_op, head_op;
    logic                   front_valid, q_ready, head_valid, q_pop, q_push;
    l3cg_pkg::opq_stat_t    q_stat;
    l3cg_pkg::back_stat_t   back_stat;

    // Front: mode register, index and address forming
    l3cg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .pix_in     (pix_in),
        .op         (front_op),
        .op_valid   (front_valid),
        .op_ready   (q_ready)
    );

    // Request queue between front and back
    l3cg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (q_ready),
        .head_op    (head_op),
        .head_valid (head_valid),
        .pop        (q_pop),
        .stat       (q_stat)
    );

    // Back: cube store, interpolation pipeline, output queue
    l3cg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (head_op),
        .head_valid (head_valid),
        .pop        (q_pop),
        .res_out    (res_out),
        .stat       (back_stat)
    );

    assign q_push = front_valid && q_ready;

    // A request taken without a pop grows the queue by one
    a_queue_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 3'd1))
        else $error("request queue count lost a request");

    // Reserved output slots cover every queued result
    a_credits_cover : assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.credits >= back_stat.out_count)
        else $error("output queue holds more results than credits");

    // Credits never exceed the output queue depth
    a_credit_limit : assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.credits <= l3cg_pkg::OUTQ_CNT_W'(l3cg_pkg::OUTQ_DEPTH))
        else $error("output credits overrun");

    // No result without an outstanding grade
    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.credits == '0) |-> !res_out.valid)
        else $error("result shown with no grade outstanding");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

    // One request as queued for the driver, with the idle gap that follows it
    typedef struct packed
    {
        l3cg_pkg::cmd_t                    command;
        logic [l3cg_pkg::ADDR_W-1:0]       index;
        logic [l3cg_pkg::CH_W-1:0]         red16;
        logic [l3cg_pkg::CH_W-1:0]         green16;
        logic [l3cg_pkg::CH_W-1:0]         blue16;
        logic [l3cg_pkg::PIX_W-1:0]        red8;
        logic [l3cg_pkg::PIX_W-1:0]        green8;
        logic [l3cg_pkg::PIX_W-1:0]        blue8;
        logic [7:0]                        gap;
    } request_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_data;

    l3cg_in_if  pix_in ();
    l3cg_out_if res_out ();

    lut3d_color_grade i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .res_out   (res_out)
    );

    request_t                       pending[$];
    l3cg_pkg::result_t              graded_expect[$];
    logic [l3cg_pkg::ENTRY_W-1:0]   cube_mem [l3cg_pkg::STORE_DEPTH];
    bit                             entry_loaded [l3cg_pkg::STORE_DEPTH];
    l3cg_pkg::edge_mode_t           grade_mode;
    request_t                       next_req;
    l3cg_pkg::result_t              oldest_grade;
    bit                             steady;
    bit                             req_taken;
    bit                             long_hold_done;
    int unsigned                    idle_left;
    int unsigned                    cur_gap;
    int unsigned                    stall_left;
    int unsigned                    flow_left;
    int unsigned                    results_seen;
    int unsigned                    queued_total;
    int unsigned                    fail_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Grading predictor
    // ---------------------------------------------------------------
    function automatic int unsigned cell_width(l3cg_pkg::edge_mode_t m);
        return (m == l3cg_pkg::EDGE_16) ? l3cg_pkg::CELL_SMALL : l3cg_pkg::CELL_LARGE;
    endfunction

    // Cube index on one axis, clamped so the far corner stays inside the cube
    function automatic int unsigned cube_index(logic [l3cg_pkg::PIX_W-1:0] v,
                                               l3cg_pkg::edge_mode_t m);
        int unsigned top;
        int unsigned i;
        top = (m == l3cg_pkg::EDGE_16) ? l3cg_pkg::IDX_MAX_SMALL : l3cg_pkg::IDX_MAX_LARGE;
        i   = v / cell_width(m);
        return (i > top) ? top : i;
    endfunction

    function automatic logic [l3cg_pkg::ADDR_W-1:0] corner_addr
    (
        logic [l3cg_pkg::PIX_W-1:0] r, g, b,
        l3cg_pkg::edge_mode_t       m,
        bit                         diagonal
    );
        int unsigned side;
        int unsigned step;
        side = (m == l3cg_pkg::EDGE_16) ? l3cg_pkg::SMALL_EDGE : l3cg_pkg::CUBE_EDGE;
        step = diagonal ? 1 : 0;
        return l3cg_pkg::ADDR_W'((cube_index(r, m) + step) + (cube_index(g, m) + step) * side
                                 + (cube_index(b, m) + step) * side * side);
    endfunction

    // Linear blend of two 16-bit levels, scaled to 8 bits, truncated and saturated
    function automatic logic [l3cg_pkg::PIX_W-1:0] blend(int unsigned s, int unsigned e,
                                                         int unsigned f, int unsigned cell_w);
        int unsigned q;
        q = (s * (cell_w - f) + e * f) / (257 * cell_w);
        return (q > 255) ? 8'd255 : l3cg_pkg::PIX_W'(q);
    endfunction

    function automatic l3cg_pkg::result_t grade_pixel(logic [l3cg_pkg::PIX_W-1:0] r, g, b);
        int unsigned                    cell_w;
        logic [l3cg_pkg::ENTRY_W-1:0]   near_c;
        logic [l3cg_pkg::ENTRY_W-1:0]   far_c;
        l3cg_pkg::result_t              res;
        cell_w = cell_width(grade_mode);
        near_c = cube_mem[corner_addr(r, g, b, grade_mode, 1'b0)];
        far_c  = cube_mem[corner_addr(r, g, b, grade_mode, 1'b1)];
        res.red   = blend(near_c[2*l3cg_pkg::CH_W +: l3cg_pkg::CH_W],
                          far_c[2*l3cg_pkg::CH_W +: l3cg_pkg::CH_W], r % cell_w, cell_w);
        res.green = blend(near_c[l3cg_pkg::CH_W +: l3cg_pkg::CH_W],
                          far_c[l3cg_pkg::CH_W +: l3cg_pkg::CH_W], g % cell_w, cell_w);
        res.blue  = blend(near_c[0 +: l3cg_pkg::CH_W],
                          far_c[0 +: l3cg_pkg::CH_W], b % cell_w, cell_w);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly no gap, some short ones, a few long
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic logic [l3cg_pkg::CH_W-1:0] level();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '0;
        else if (roll < 40)
            return '1;
        else
            return l3cg_pkg::CH_W'($urandom);
    endfunction

    // Bias towards the clamped top cell and the bottom corner
    function automatic logic [l3cg_pkg::PIX_W-1:0] rand_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return l3cg_pkg::PIX_W'($urandom_range(240, 255));
        else if (roll < 30)
            return l3cg_pkg::PIX_W'($urandom_range(0, 15));
        else
            return l3cg_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    // Same cell, new fraction
    function automatic logic [l3cg_pkg::PIX_W-1:0] same_cell(logic [l3cg_pkg::PIX_W-1:0] v);
        int unsigned mask;
        mask = cell_width(grade_mode) - 1;
        return (v & ~l3cg_pkg::PIX_W'(mask)) | l3cg_pkg::PIX_W'($urandom_range(0, mask));
    endfunction

    task automatic push_load(logic [l3cg_pkg::ADDR_W-1:0] idx,
                             logic [l3cg_pkg::CH_W-1:0] r, g, b);
        request_t item;
        item.command = l3cg_pkg::CMD_LOAD;
        item.index   = idx;
        item.red16   = r;
        item.green16 = g;
        item.blue16  = b;
        item.red8    = l3cg_pkg::PIX_W'($urandom);
        item.green8  = l3cg_pkg::PIX_W'($urandom);
        item.blue8   = l3cg_pkg::PIX_W'($urandom);
        item.gap     = steady ? 8'd0 : 8'(idle_length());
        pending.insert(pending.size(), item);
        entry_loaded[idx] = 1'b1;
        queued_total++;
    endtask

    // Load both corners a pixel will read; fresh forces new contents
    task automatic push_corners(logic [l3cg_pkg::PIX_W-1:0] r, g, b, bit fresh);
        logic [l3cg_pkg::ADDR_W-1:0] base_a;
        logic [l3cg_pkg::ADDR_W-1:0] diag_a;
        base_a = corner_addr(r, g, b, grade_mode, 1'b0);
        diag_a = corner_addr(r, g, b, grade_mode, 1'b1);
        if (fresh || !entry_loaded[base_a])
            push_load(base_a, level(), level(), level());
        if (fresh || !entry_loaded[diag_a])
            push_load(diag_a, level(), level(), level());
    endtask

    task automatic push_grade(logic [l3cg_pkg::PIX_W-1:0] r, g, b, bit fresh);
        request_t item;
        push_corners(r, g, b, fresh);
        item.command = l3cg_pkg::CMD_GRADE;
        item.index   = l3cg_pkg::ADDR_W'($urandom);
        item.red16   = l3cg_pkg::CH_W'($urandom);
        item.green16 = l3cg_pkg::CH_W'($urandom);
        item.blue16  = l3cg_pkg::CH_W'($urandom);
        item.red8    = r;
        item.green8  = g;
        item.blue8   = b;
        item.gap     = steady ? 8'd0 : 8'(idle_length());
        pending.insert(pending.size(), item);
        queued_total++;
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned                start;
        int unsigned                kind;
        int unsigned                reps;
        logic [l3cg_pkg::PIX_W-1:0] r;
        logic [l3cg_pkg::PIX_W-1:0] g;
        logic [l3cg_pkg::PIX_W-1:0] b;
        start = queued_total;
        while (queued_total - start < n)
        begin
            if ($urandom_range(0, 49) == 0)
                steady = !steady;
            kind = $urandom_range(0, 99);
            r = rand_pixel();
            g = rand_pixel();
            b = rand_pixel();
            if (kind < 12)
                push_load(l3cg_pkg::ADDR_W'($urandom_range(0, l3cg_pkg::STORE_DEPTH - 1)),
                          level(), level(), level());
            else if (kind < 20)
                push_corners(r, g, b, 1'b1);
            else if (kind < 75)
            begin
                // fresh corners, then up to two more pixels in the same cell
                push_grade(r, g, b, 1'b1);
                reps = $urandom_range(0, 2);
                repeat (reps)
                    push_grade(same_cell(r), same_cell(g), same_cell(b), 1'b0);
            end
            else
                push_grade(r, g, b, 1'b0);
        end
        steady = 1'b0;
    endtask

    // Wait for the block to drain, then for queued loads to reach the cube store
    task automatic settle();
        while (pending.size() != 0 || pix_in.valid || graded_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_edge_mode(l3cg_pkg::edge_mode_t m);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        grade_mode = m;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic check_channel(string name, logic [l3cg_pkg::PIX_W-1:0] want,
                                 logic [l3cg_pkg::PIX_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: graded %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_data       = 1'b0;
        pix_in.valid   = 1'b0;
        pix_in.command = l3cg_pkg::CMD_LOAD;
        pix_in.entry_index = '0;
        pix_in.entry_red   = '0;
        pix_in.entry_green = '0;
        pix_in.entry_blue  = '0;
        pix_in.pixel_red   = '0;
        pix_in.pixel_green = '0;
        pix_in.pixel_blue  = '0;
        res_out.ready  = 1'b0;
        grade_mode     = l3cg_pkg::EDGE_32;
        steady         = 1'b0;
        req_taken      = 1'b0;
        long_hold_done = 1'b0;
        idle_left      = 0;
        cur_gap        = 0;
        stall_left     = 0;
        flow_left      = 0;
        results_seen   = 0;
        queued_total   = 0;
        fail_count     = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Large cube (cell width 8): bottom corner, zero and full fractions, clamped top cell
        set_edge_mode(l3cg_pkg::EDGE_32);
        push_load(l3cg_pkg::ADDR_W'(0), '0, '0, '0);
        push_load(l3cg_pkg::ADDR_W'(1057), '1, '1, '1);
        push_grade(8'd0, 8'd0, 8'd0, 1'b0);
        push_grade(8'd7, 8'd7, 8'd7, 1'b0);
        push_grade(8'd3, 8'd6, 8'd1, 1'b0);
        push_load(l3cg_pkg::ADDR_W'(31710), '0, '1, 16'h1234);
        push_load(l3cg_pkg::ADDR_W'(l3cg_pkg::STORE_DEPTH - 1), '1, '0, 16'hEDCB);
        push_grade(8'd255, 8'd255, 8'd255, 1'b0);
        push_grade(8'd248, 8'd240, 8'd252, 1'b0);
        push_grade(8'hAA, 8'h55, 8'h0F, 1'b1);
        settle();

        // Small cube (cell width 16): same cases with the wider cell
        set_edge_mode(l3cg_pkg::EDGE_16);
        push_load(l3cg_pkg::ADDR_W'(0), '1, '0, 16'h8000);
        push_load(l3cg_pkg::ADDR_W'(273), '0, '1, 16'h8000);
        push_grade(8'd0, 8'd0, 8'd0, 1'b0);
        push_grade(8'd15, 8'd15, 8'd15, 1'b0);
        push_grade(8'd9, 8'd4, 8'd12, 1'b0);
        push_load(l3cg_pkg::ADDR_W'(3822), 16'h0101, '1, '0);
        push_load(l3cg_pkg::ADDR_W'(4095), '1, 16'h7FFF, '1);
        push_grade(8'd255, 8'd255, 8'd255, 1'b0);
        push_grade(8'd224, 8'd240, 8'd255, 1'b0);

        random_phase(500);
        settle();
        set_edge_mode(l3cg_pkg::EDGE_32);
        random_phase(500);
        settle();
        set_edge_mode(l3cg_pkg::EDGE_16);
        random_phase(500);
        settle();
        set_edge_mode(l3cg_pkg::EDGE_32);
        random_phase(500);
        settle();

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pix_in.valid <= 1'b0;
        else if (pix_in.valid && !req_taken)
        begin
            // hold the request until it is taken
        end
        else
        begin
            if (pix_in.valid)
                idle_left = cur_gap;
            if (idle_left == 0 && pending.size() != 0)
            begin
                next_req = pending.pop_front();
                pix_in.valid       <= 1'b1;
                pix_in.command     <= next_req.command;
                pix_in.entry_index <= next_req.index;
                pix_in.entry_red   <= next_req.red16;
                pix_in.entry_green <= next_req.green16;
                pix_in.entry_blue  <= next_req.blue16;
                pix_in.pixel_red   <= next_req.red8;
                pix_in.pixel_green <= next_req.green8;
                pix_in.pixel_blue  <= next_req.blue8;
                cur_gap = next_req.gap;
            end
            else
            begin
                pix_in.valid <= 1'b0;
                if (idle_left > 0)
                    idle_left--;
            end
        end
    end

    // Accepted requests update the cube copy or queue an expected pixel
    always @(posedge clk)
    begin
        req_taken <= rst_n && pix_in.valid && pix_in.ready;
        if (rst_n && pix_in.valid && pix_in.ready)
        begin
            if (pix_in.command == l3cg_pkg::CMD_LOAD)
                cube_mem[pix_in.entry_index] = {pix_in.entry_red, pix_in.entry_green,
                                                pix_in.entry_blue};
            else
                graded_expect.insert(graded_expect.size(),
                                     grade_pixel(pix_in.pixel_red, pix_in.pixel_green,
                                                 pix_in.pixel_blue));
        end
    end

    // ---------------------------------------------------------------
    // Result receiver
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            res_out.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_out.ready <= 1'b0;
            stall_left--;
        end
        else if (!long_hold_done && results_seen >= 150)
        begin
            // long back-pressure: both queues fill and pix_in.ready drops
            res_out.ready <= 1'b0;
            stall_left = 400;
            long_hold_done = 1'b1;
        end
        else if (flow_left > 0)
        begin
            res_out.ready <= 1'b1;
            flow_left--;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            res_out.ready <= 1'b1;
            flow_left = 100;
        end
        else
        begin
            stall_left = idle_length();
            res_out.ready <= (stall_left == 0);
        end
    end

    // Compare each graded pixel with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_out.valid && res_out.ready)
        begin
            results_seen++;
            if (graded_expect.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d", $time,
                         res_out.graded_red, res_out.graded_green, res_out.graded_blue);
                fail_count++;
            end
            else
            begin
                oldest_grade = graded_expect.pop_front();
                check_channel("red", oldest_grade.red, res_out.graded_red);
                check_channel("green", oldest_grade.green, res_out.graded_green);
                check_channel("blue", oldest_grade.blue, res_out.graded_blue);
            end
        end
    end

endmodule
